[src/tro_pkg.sv]
package tro_pkg;

    localparam int TS_W         = 48;
    localparam int ENG_W        = 6;
    localparam int CH_W         = 12;
    localparam int MASK_W       = 64;
    localparam int STEP_W       = 21;
    localparam int LIM_W        = 16;
    localparam int JT_W         = 16;
    localparam int CNT_W        = 32;
    localparam int QW           = TS_W + 1;   // signed offset / quotient magnitude
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = STEP_W;
    localparam int ENGINE_COUNT = 64;
    localparam int WINDOW_SLOTS_DEF = 16;

    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(2048);
    localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(256);
    localparam logic [JT_W-1:0]   JT_RST   = JT_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP  = 2'd2;

    typedef enum logic [1:0] {
        KIND_EMIT    = 2'd0,
        KIND_STORED  = 2'd1,
        KIND_LATE    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef struct packed {
        logic  load_in;
        logic  div_start;
        logic  clear_base;
        logic  base_from_stamp;
        logic  base_from_ts;
        logic  late_inc;
        logic  q_load;
        logic  q_clear;
        logic  clear_all;
        logic  sel_place;
        logic  pop_adv;
        logic  place_wr;
        logic  out_load;
        logic  out_slot;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic q_gt_lim;
        logic q_gt_jump;
        logic q_ge_w;
        logic base_gt_ts;
        logic head_used;
        logic out_free;
    } t_stat;

endpackage

[src/tro_div.sv]
module tro_div
    import tro_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW-1:0]     i_num,
    input  logic [STEP_W-1:0] i_den,
    output logic              o_done,
    output logic [QW-1:0]     o_quo
);
    localparam int CW = $clog2(QW + 1);

    logic [STEP_W:0]   r_rem;
    logic [QW-1:0]     r_quo;
    logic [STEP_W-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic [STEP_W+1:0] trial;
    logic [STEP_W+1:0] shifted;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_quo[QW-1]};
        trial   = shifted - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!trial[STEP_W+1]) begin
                r_rem <= trial[STEP_W:0];
            end else begin
                r_rem <= shifted[STEP_W:0];
            end
            r_quo <= {r_quo[QW-2:0], ~trial[STEP_W+1]};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;
endmodule

[src/tro_datapath.sv]
module tro_datapath
    import tro_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TS_W-1:0]       i_pkt_timestamp,
    input  logic [ENG_W-1:0]      i_engine_id,
    input  logic [CH_W-1:0]       i_channel_base,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_kind,
    output logic [TS_W-1:0]       o_slot_time,
    output logic [CH_W-1:0]       o_slot_channel,
    output logic [MASK_W-1:0]     o_engine_mask,
    output logic                  o_last
);
    localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    // configuration
    logic [STEP_W-1:0] r_step;
    logic [LIM_W-1:0]  r_lim;
    logic [JT_W-1:0]   r_jt;

    // latched packet
    logic [TS_W-1:0]   r_ts;
    logic [ENG_W-1:0]  r_eng;
    logic [CH_W-1:0]   r_ch;

    // window state
    logic [WINDOW_SLOTS-1:0] r_used;
    logic [AW-1:0]     r_head;
    logic [TS_W-1:0]   r_base;
    logic [CNT_W-1:0]  r_late_cnt;
    logic [CNT_W-1:0]  r_pkt_cnt;
    logic [QW-1:0]     r_q;

    logic [TS_W-1:0]   mem_stamp [WINDOW_SLOTS];
    logic [CH_W-1:0]   mem_freq  [WINDOW_SLOTS];
    logic [MASK_W-1:0] mem_eng   [WINDOW_SLOTS];
    logic [TS_W-1:0]   r_rd_stamp;
    logic [CH_W-1:0]   r_rd_freq;
    logic [MASK_W-1:0] r_rd_eng;

    // output word
    logic              r_o_valid;
    t_kind             r_o_kind;
    logic [TS_W-1:0]   r_o_time;
    logic [CH_W-1:0]   r_o_ch;
    logic [MASK_W-1:0] r_o_mask;
    logic              r_o_last;

    logic [QW-1:0]     diff;
    logic [QW-1:0]     num;
    logic [STEP_W-1:0] step_eff;
    logic              div_done;
    logic [QW-1:0]     div_quo;
    logic [AW:0]       psum;
    logic [AW-1:0]     place_idx;
    logic [AW-1:0]     rd_addr;
    logic [MASK_W-1:0] eng_bit;

    always_comb begin
        diff     = {1'b0, r_ts} - {1'b0, r_base};
        num      = diff[QW-1] ? (~diff + QW'(1)) : diff;
        step_eff = (r_step == '0) ? STEP_W'(1) : r_step;
        psum     = {1'b0, r_head} + {1'b0, r_q[AW-1:0]};
        if (psum >= (AW+1)'(WINDOW_SLOTS)) begin
            psum = psum - (AW+1)'(WINDOW_SLOTS);
        end
        place_idx = psum[AW-1:0];
        rd_addr   = i_cmd.sel_place ? place_idx : r_head;
        eng_bit   = ({1'b0, r_eng} < (ENG_W+1)'(ENGINE_COUNT)) ?
                    (MASK_W'(1) << r_eng) : '0;
    end

    tro_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (step_eff),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        o_stat.div_done   = div_done;
        o_stat.q_gt_lim   = r_q > QW'(r_lim);
        o_stat.q_gt_jump  = r_q > (QW'(WINDOW_SLOTS) + QW'(r_jt));
        o_stat.q_ge_w     = r_q >= QW'(WINDOW_SLOTS);
        o_stat.base_gt_ts = r_base > r_ts;
        o_stat.head_used  = r_used[r_head];
        o_stat.out_free   = !r_o_valid || !i_out_stall;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_RST;
            r_lim      <= LIM_RST;
            r_jt       <= JT_RST;
            r_used     <= '0;
            r_head     <= '0;
            r_base     <= '0;
            r_late_cnt <= '0;
            r_pkt_cnt  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP:  r_step <= i_cfg_data;
                    CFG_LIMIT: r_lim  <= i_cfg_data[LIM_W-1:0];
                    CFG_JUMP:  r_jt   <= i_cfg_data[JT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_pkt_cnt <= r_pkt_cnt + 1'b1;
            end
            if (i_cmd.late_inc) begin
                r_late_cnt <= r_late_cnt + 1'b1;
            end
            if (i_cmd.clear_base) begin
                r_base <= '0;
            end else if (i_cmd.base_from_stamp) begin
                r_base <= r_rd_stamp;
            end else if (i_cmd.base_from_ts) begin
                r_base <= r_ts;
            end
            if (i_cmd.clear_all) begin
                r_used <= '0;
                r_head <= '0;
            end else if (i_cmd.pop_adv) begin
                r_used[r_head] <= 1'b0;
                r_head <= (r_head == AW'(WINDOW_SLOTS - 1)) ? '0 : r_head + 1'b1;
            end else if (i_cmd.place_wr) begin
                r_used[place_idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ts  <= i_pkt_timestamp;
            r_eng <= i_engine_id;
            r_ch  <= i_channel_base;
        end
        if (i_cmd.q_clear) begin
            r_q <= '0;
        end else if (i_cmd.q_load) begin
            r_q <= div_quo;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_slot) begin
                r_o_time <= r_rd_stamp;
                r_o_ch   <= r_rd_freq;
                r_o_mask <= r_rd_eng;
                r_o_last <= 1'b0;
            end else begin
                r_o_time <= r_ts;
                r_o_ch   <= r_ch;
                r_o_mask <= '0;
                r_o_last <= 1'b1;
            end
            r_o_kind <= i_cmd.out_kind;
        end
    end

    // slot memories: one registered read port, one write port
    always_ff @(posedge i_clk) begin
        r_rd_stamp <= mem_stamp[rd_addr];
        r_rd_freq  <= mem_freq[rd_addr];
        r_rd_eng   <= mem_eng[rd_addr];
        if (i_cmd.place_wr) begin
            if (r_used[place_idx]) begin
                mem_eng[place_idx] <= r_rd_eng | eng_bit;
            end else begin
                mem_stamp[place_idx] <= r_ts;
                mem_freq[place_idx]  <= r_ch;
                mem_eng[place_idx]   <= eng_bit;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_slot_time    = r_o_time;
    assign o_slot_channel = r_o_ch;
    assign o_engine_mask  = r_o_mask;
    assign o_last         = r_o_last;
endmodule

[src/tro_ctrl.sv]
module tro_ctrl
    import tro_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam int PW = $clog2(WINDOW_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV0, S_DIV1, S_CHK1, S_RESDIV, S_DIV2, S_DECIDE,
        S_POP_CHK, S_POP_EMIT, S_POP_ADV, S_POP_NH, S_POP_BASE,
        S_POP_CMP, S_POP_DIV, S_POP_Q, S_PLACE_RD
    } t_state;

    // S_PLACE_WR and S_STATUS are kept as separate flags to stay in a 4-bit code
    t_state r_state, n_state;
    logic   r_wr, n_wr;          // place write step
    logic   r_st, n_st;          // status word step
    logic   r_beyond, n_beyond;
    t_kind  r_kind, n_kind;
    logic [PW-1:0] r_pops, n_pops;

    always_comb begin
        n_state  = r_state;
        n_wr     = 1'b0;
        n_st     = r_st;
        n_beyond = r_beyond;
        n_kind   = r_kind;
        n_pops   = r_pops;
        o_cmd    = '0;
        o_cmd.out_kind = r_kind;

        if (r_wr) begin
            o_cmd.sel_place = 1'b1;
            o_cmd.place_wr  = 1'b1;
            n_st = 1'b1;
        end else if (r_st) begin
            if (i_stat.out_free) begin
                o_cmd.out_load = 1'b1;
                n_st    = 1'b0;
                n_state = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.load_in = 1'b1;
                        n_state = S_DIV0;
                    end
                end
                S_DIV0: begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV1;
                end
                S_DIV1: begin
                    if (i_stat.div_done) begin
                        o_cmd.q_load = 1'b1;
                        n_state = S_CHK1;
                    end
                end
                S_CHK1: begin
                    if (i_stat.q_gt_lim) begin
                        o_cmd.clear_base = 1'b1;
                        n_state = S_RESDIV;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
                S_RESDIV: begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV2;
                end
                S_DIV2: begin
                    if (i_stat.div_done) begin
                        o_cmd.q_load = 1'b1;
                        n_state = S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    n_kind = KIND_STORED;
                    if (i_stat.base_gt_ts) begin
                        o_cmd.late_inc = 1'b1;
                        n_kind = KIND_LATE;
                        n_st   = 1'b1;
                    end else if (i_stat.q_gt_jump) begin
                        o_cmd.clear_all    = 1'b1;
                        o_cmd.q_clear      = 1'b1;
                        o_cmd.base_from_ts = 1'b1;
                        n_kind  = KIND_RESTART;
                        n_state = S_PLACE_RD;
                    end else if (i_stat.q_ge_w) begin
                        n_beyond = 1'b1;
                        n_pops   = '0;
                        n_state  = S_POP_CHK;
                    end else begin
                        n_state = S_PLACE_RD;
                    end
                end
                S_POP_CHK: begin
                    if ((r_beyond || !i_stat.head_used) && r_pops != PW'(WINDOW_SLOTS)) begin
                        n_state = i_stat.head_used ? S_POP_EMIT : S_POP_ADV;
                    end else begin
                        if (r_pops == PW'(WINDOW_SLOTS)) begin
                            o_cmd.q_clear      = 1'b1;
                            o_cmd.base_from_ts = 1'b1;
                        end
                        n_state = S_PLACE_RD;
                    end
                end
                S_POP_EMIT: begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_slot = 1'b1;
                        o_cmd.out_kind = KIND_EMIT;
                        n_state = S_POP_ADV;
                    end
                end
                S_POP_ADV: begin
                    o_cmd.pop_adv = 1'b1;
                    n_pops  = r_pops + 1'b1;
                    n_state = S_POP_NH;
                end
                S_POP_NH: begin
                    n_state = i_stat.head_used ? S_POP_BASE : S_POP_CHK;
                end
                S_POP_BASE: begin
                    o_cmd.base_from_stamp = 1'b1;
                    n_state = S_POP_CMP;
                end
                S_POP_CMP: begin
                    if (i_stat.base_gt_ts) begin
                        n_beyond = 1'b1;
                        n_state  = S_POP_CHK;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_POP_DIV;
                    end
                end
                S_POP_DIV: begin
                    if (i_stat.div_done) begin
                        o_cmd.q_load = 1'b1;
                        n_state = S_POP_Q;
                    end
                end
                S_POP_Q: begin
                    n_beyond = i_stat.q_ge_w;
                    n_state  = S_POP_CHK;
                end
                S_PLACE_RD: begin
                    o_cmd.sel_place = 1'b1;
                    n_wr = 1'b1;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr     <= 1'b0;
            r_st     <= 1'b0;
            r_beyond <= 1'b0;
            r_kind   <= KIND_STORED;
            r_pops   <= '0;
        end else begin
            r_state  <= n_state;
            r_wr     <= n_wr;
            r_st     <= n_st;
            r_beyond <= n_beyond;
            r_kind   <= n_kind;
            r_pops   <= n_pops;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || r_wr || r_st;
endmodule

[src/timestamp_reorder_window_top.sv]
// Timestamp reorder window.
// Input channel (i_in_valid / o_in_stall) carries one packet word: timestamp,
// engine id, channel. Output channel (o_out_valid / i_out_stall) returns, per
// packet, zero or more emitted-slot words (kind 0, last 0) followed by one
// status word (kind 1 stored, 2 late, 3 restart; last 1).
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data. The user must see that it is
// written only while idle; the block itself does not enforce this. One packet
// is handled at a time. The slot offset comes from a 1-bit-per-cycle divider.
// A plain store's status word reaches the output in the same cycle in which
// the next packet can be taken; a resync adds one more division. Each slot
// popped while sliding passes the check, advance and next-head steps, and an
// emitted one also the emit step; when the new head slot is occupied and its
// stamp is not beyond the packet's timestamp, a division follows.
// Reset (synchronous, active low) empties the window, zeroes the base and
// counters and loads register defaults; no clearing pass is needed.
// A stalled receiver freezes the output word; the controller waits before
// loading the next word, and o_in_stall stays high until the status word of
// the current packet has been loaded into the output register.
module timestamp_reorder_window_top
    import tro_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TS_W-1:0]       i_pkt_timestamp,
    input  logic [ENG_W-1:0]      i_engine_id,
    input  logic [CH_W-1:0]       i_channel_base,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_kind,
    output logic [TS_W-1:0]       o_slot_time,
    output logic [CH_W-1:0]       o_slot_channel,
    output logic [MASK_W-1:0]     o_engine_mask,
    output logic                  o_last
);
    t_cmd  cmd;
    t_stat stat;

    // sequencing of divide, slide and place steps
    tro_ctrl #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // slot store, base, divider and output register
    tro_datapath #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pkt_timestamp (i_pkt_timestamp),
        .i_engine_id     (i_engine_id),
        .i_channel_base  (i_channel_base),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_slot_time     (o_slot_time),
        .o_slot_channel  (o_slot_channel),
        .o_engine_mask   (o_engine_mask),
        .o_last          (o_last)
    );
endmodule

[dv/tb_top.sv]
module tb_top
    import tro_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = WINDOW_SLOTS_DEF;
    localparam int IDLE_LIMIT = 20000;  // cycles with no word moving on either side

    // One packet word as queued for the driver.
    typedef struct {
        logic [TS_W-1:0]  ts;
        logic [ENG_W-1:0] eng;
        logic [CH_W-1:0]  ch;
    } t_pkt_word;

    // One output word: emitted slot or per-packet status.
    typedef struct {
        t_kind             kind;
        logic [TS_W-1:0]   stamp;
        logic [CH_W-1:0]   ch;
        logic [MASK_W-1:0] mask;
        logic              last;
    } t_window_word;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TS_W-1:0]       pkt_ts = '0;
    logic [ENG_W-1:0]      pkt_eng = '0;
    logic [CH_W-1:0]       pkt_ch = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            out_kind;
    logic [TS_W-1:0]       out_time;
    logic [CH_W-1:0]       out_ch;
    logic [MASK_W-1:0]     out_mask;
    logic                  out_last;

    timestamp_reorder_window_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_pkt_timestamp (pkt_ts),
        .i_engine_id     (pkt_eng),
        .i_channel_base  (pkt_ch),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (out_kind),
        .o_slot_time     (out_time),
        .o_slot_channel  (out_ch),
        .o_engine_mask   (out_mask),
        .o_last          (out_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_pkt_word    pending_pkts[$];
    t_window_word expected_words[$];

    // Idle rates in percent, changed per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned n_mismatch = 0;
    int unsigned n_pkts_in = 0;
    int unsigned n_words_out = 0;
    int unsigned n_emits = 0;
    int unsigned n_late = 0;
    int unsigned n_restart = 0;
    int unsigned quiet_cycles = 0;

    // ---------------- window predictor state ----------------
    logic [STEP_W-1:0] cur_step  = STEP_RST;
    logic [LIM_W-1:0]  cur_limit = LIM_RST;
    logic [JT_W-1:0]   cur_jump  = JT_RST;

    logic              w_used [NSLOT];
    logic [TS_W-1:0]   w_stamp[NSLOT];
    logic [CH_W-1:0]   w_chan [NSLOT];
    logic [MASK_W-1:0] w_eng  [NSLOT];
    int unsigned       w_head = 0;
    logic [TS_W-1:0]   w_base = '0;

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            w_used[i] = 1'b0;
            w_eng[i]  = '0;
        end
    end

    function automatic longint eff_step();
        return (cur_step == 0) ? 64'sd1 : longint'(cur_step);
    endfunction

    // Merge a packet into window slot k (counted from the head).
    function automatic void place_pkt(int unsigned k, logic [TS_W-1:0] ts,
                                      logic [CH_W-1:0] ch, logic [MASK_W-1:0] bitv);
        int unsigned p;
        p = (w_head + k) % NSLOT;
        if (w_used[p]) begin
            w_eng[p] |= bitv;
        end else begin
            w_used[p]  = 1'b1;
            w_stamp[p] = ts;
            w_chan[p]  = ch;
            w_eng[p]   = bitv;
        end
    endfunction

    function automatic void push_word(t_kind k, logic [TS_W-1:0] t, logic [CH_W-1:0] ch,
                                      logic [MASK_W-1:0] m, logic l);
        t_window_word w;
        w.kind = k;
        w.stamp = t;
        w.ch = ch;
        w.mask = m;
        w.last = l;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Advance the window by one packet and queue the words it produces.
    function automatic void predict_packet(t_pkt_word pk);
        longint step, lim, q, tsl;
        logic [MASK_W-1:0] bitv;
        t_kind kind;
        int unsigned pops, p;
        bit beyond;
        step = eff_step();
        lim  = longint'(cur_limit);
        tsl  = longint'({16'd0, pk.ts});
        bitv = (int'(pk.eng) < ENGINE_COUNT) ? (64'd1 << pk.eng) : '0;
        kind = KIND_STORED;

        q = (tsl - longint'({16'd0, w_base})) / step;
        if (q > lim || q < -lim) begin
            w_base = '0;
            q = tsl / step;
        end

        if (w_base > pk.ts) begin
            kind = KIND_LATE;
        end else if (q > longint'(NSLOT) + longint'(cur_jump)) begin
            for (int i = 0; i < NSLOT; i++) begin
                w_used[i] = 1'b0;
                w_eng[i]  = '0;
            end
            w_head = 0;
            place_pkt(0, pk.ts, pk.ch, bitv);
            w_base = pk.ts;
            kind = KIND_RESTART;
        end else if (q >= NSLOT) begin
            pops = 0;
            beyond = 1'b1;
            while ((beyond || !w_used[w_head]) && pops != NSLOT) begin
                p = w_head;
                if (w_used[p])
                    push_word(KIND_EMIT, w_stamp[p], w_chan[p], w_eng[p], 1'b0);
                w_used[p] = 1'b0;
                w_eng[p]  = '0;
                w_head = (w_head + 1) % NSLOT;
                p = w_head;
                if (w_used[p]) begin
                    w_base = w_stamp[p];
                    if (w_base > pk.ts) begin
                        beyond = 1'b1;
                    end else begin
                        q = (tsl - longint'({16'd0, w_base})) / step;
                        beyond = (q >= NSLOT);
                    end
                end
                pops++;
            end
            if (pops == NSLOT) begin
                place_pkt(0, pk.ts, pk.ch, bitv);
                w_base = pk.ts;
            end else begin
                place_pkt(int'(q), pk.ts, pk.ch, bitv);
            end
        end else begin
            place_pkt(int'(q), pk.ts, pk.ch, bitv);
        end
        push_word(kind, pk.ts, pk.ch, '0, 1'b1);
    endfunction

    function automatic void queue_pkt(logic [TS_W-1:0] ts, logic [ENG_W-1:0] eng,
                                      logic [CH_W-1:0] ch);
        t_pkt_word pk;
        pk.ts = ts;
        pk.eng = eng;
        pk.ch = ch;
        predict_packet(pk);
        pending_pkts.insert(pending_pkts.size(), pk);
    endfunction

    // Random packet steered by the predicted base, so most packets land in or
    // just past the window; the rest are late, far jumps, resyncs or noise.
    function automatic void queue_random_pkt();
        longint step, base, ts;
        int unsigned sel;
        step = eff_step();
        base = longint'({16'd0, w_base});
        sel  = $urandom_range(0, 99);
        if (sel < 55)
            ts = base + step * $urandom_range(0, NSLOT - 1) +
                 $urandom_range(0, 32'(step - 1));
        else if (sel < 72)
            ts = base + step * (NSLOT + $urandom_range(0, 3));
        else if (sel < 80)
            ts = base + step * (NSLOT + 1 + longint'(cur_jump) + $urandom_range(0, 5));
        else if (sel < 87)
            ts = (base > 0) ? base - $urandom_range(1, 32'(step * 3)) : 0;
        else if (sel < 93)
            ts = base + step * (longint'(cur_limit) + 1 + $urandom_range(0, 8));
        else
            ts = longint'({$urandom, $urandom}) & 64'hFFFF_FFFF_FFFF;
        queue_pkt(ts[TS_W-1:0], ENG_W'($urandom_range(0, 63)), CH_W'($urandom));
    endfunction

    // ---------------- word driver ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid)
                n_pkts_in <= n_pkts_in + 1;
            if (pending_pkts.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_pkt_word pk;
                pk = pending_pkts[0];
                pending_pkts.delete(0);
                in_valid <= 1'b1;
                pkt_ts   <= pk.ts;
                pkt_eng  <= pk.eng;
                pkt_ch   <= pk.ch;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- word monitor / checker ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_words_out <= n_words_out + 1;
                if (expected_words.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t unexpected word kind=%0d time=%h", $realtime,
                                 out_kind, out_time);
                end else begin
                    t_window_word w;
                    w = expected_words[0];
                    expected_words.delete(0);
                    case (w.kind)
                        KIND_EMIT:    n_emits++;
                        KIND_LATE:    n_late++;
                        KIND_RESTART: n_restart++;
                        default: ;
                    endcase
                    if (out_kind !== w.kind || out_time !== w.stamp || out_ch !== w.ch ||
                        out_mask !== w.mask || out_last !== w.last) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("%0t exp %0d %h %h %h %b got %0d %h %h %h %b",
                                     $realtime, w.kind, w.stamp, w.ch, w.mask, w.last,
                                     out_kind, out_time, out_ch, out_mask, out_last);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: any word moving on either side restarts the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic drain();
        while (pending_pkts.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_STEP:  cur_step  = val;
            CFG_LIMIT: cur_limit = val[LIM_W-1:0];
            CFG_JUMP:  cur_jump  = val[JT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(int unsigned n, int unsigned s_idle, int unsigned r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++)
            queue_random_pkt();
        drain();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, merge, slide, restart, late, resync.
        send_idle_pct = 13;
        recv_idle_pct = 62;
        queue_pkt(48'd0, 6'd0, 12'd0);
        queue_pkt(48'd2048, 6'd63, 12'hFFF);
        queue_pkt(48'd2053, 6'd5, 12'd7);           // same slot, bits merge
        queue_pkt(48'd15 * 2048, 6'd1, 12'd1);
        queue_pkt(48'd16 * 2048, 6'd2, 12'd2);      // slide by one slot
        queue_pkt(48'd40 * 2048, 6'd3, 12'd3);      // past the jump limit: restart
        queue_pkt(48'd80 * 2048, 6'd4, 12'd4);      // far past: restart
        queue_pkt(48'd79 * 2048, 6'd9, 12'd9);      // older than base: late
        queue_pkt(48'hFFFF_FFFF_FFFF, 6'd62, 12'hABC); // resync then restart
        queue_pkt(48'hFFFF_FFFF_FFFE, 6'd10, 12'd10);  // late at top of range
        queue_pkt(48'd0, 6'd33, 12'h800);           // resync back to zero
        for (int k = 0; k < NSLOT; k++)
            queue_pkt(48'(k * 2048 + 100), 6'(k), 12'(k));
        queue_pkt(48'd17 * 2048, 6'd20, 12'd20);    // lands on the slot freed by the slide
        drain();

        run_phase(60, 13, 62);

        write_reg(CFG_STEP, 21'd1);
        write_reg(CFG_LIMIT, 21'd1);
        write_reg(CFG_JUMP, 21'd0);
        run_phase(45, 62, 13);

        write_reg(CFG_STEP, 21'd1048576);
        write_reg(CFG_LIMIT, 21'd65535);
        write_reg(CFG_JUMP, 21'd65535);
        run_phase(45, 62, 13);

        // Zero step behaves as one; base moves far with a shrinking step.
        write_reg(CFG_STEP, 21'd0);
        write_reg(CFG_LIMIT, 21'd3);
        write_reg(CFG_JUMP, 21'd2);
        run_phase(50, 0, 0);

        write_reg(CFG_STEP, 21'h1FFFFF);
        write_reg(CFG_LIMIT, 21'd40);
        write_reg(CFG_JUMP, 21'd5);
        run_phase(50, 0, 0);

        $display("covered %0d packets, %0d output words", n_pkts_in, n_words_out);
        $display("  %0d emitted slots, %0d late, %0d restarts", n_emits, n_late,
                 n_restart);
        $display("mismatches: %0d, words still expected: %0d", n_mismatch,
                 expected_words.size());
        if (n_mismatch == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
